[rtl/core/dmacc_pkg.sv]
// ----------------------------------------------------------------------------
// dmacc_pkg: shared types and constants of the DMA clear command sequencer
// Fixed field widths, register indexes, item kinds and DMA command encodings.
// ----------------------------------------------------------------------------
package dmacc_pkg;

  localparam int unsigned FbLocW    = 16;
  localparam int unsigned PatternW  = 32;
  localparam int unsigned OffsetW   = 40;
  localparam int unsigned SizeW     = 40;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned WordW     = 32;
  localparam int unsigned DoneW     = 41;
  localparam int unsigned FbShift   = 24;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 88;
  localparam int unsigned OutDataW  = 160;
  localparam int unsigned OutUserW  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FB_LOCATION  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FILL_PATTERN = 1'b1;

  // item kinds carried on the input tuser
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  localparam logic [PatternW-1:0] FILL_PATTERN_RST = 32'hdeadbeef;

  localparam logic [WordW-1:0] CTRL_FILL       = 32'h40c00c00;
  localparam logic [WordW-1:0] CTRL_COPY       = 32'h00c00c00;
  localparam logic [WordW-1:0] CMD_FILL        = 32'h54000000;
  localparam logic [WordW-1:0] CMD_COPY        = 32'h40000000;
  localparam logic [WordW-1:0] FILL_COUNT_MASK = 32'h001fffff;

  typedef struct packed {
    logic             cmd_valid;
    logic [WordW-1:0] control_word;
    logic [AddrW-1:0] source_word;
    logic [AddrW-1:0] dest_address;
    logic [WordW-1:0] command_word;
    logic             last;
    logic             status;
  } result_t;

endpackage

[rtl/core/dma_clear_command_sequencer.sv]
// ----------------------------------------------------------------------------
// dma_clear_command_sequencer: DMA command generator for clearing a region
// A start item emits a seed fill, each next item emits a doubling copy from
// the seed block to the running destination; a DMA fault aborts the clear.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tdata: offset, size, fault
//                                                  tuser: mode
// m_axis    out        m_axis_tvalid/tready        tdata: command registers
//                                                  tuser: cmd_valid, status
//                                                  tlast: last
// cfg       in         cfg_we_i (no handshake)     cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless stalled: the step logic (one 42-bit add and
// compare, a clamp and a shift) sits between input port and result register.
// The result register is refilled in the cycle it is taken, so the input only
// stalls while a result waits and m_axis_tready is low.
// A next item while idle gives no result. Reset leaves the sequencer idle
// with an empty result register; the address and count registers are loaded
// by the next start.
module dma_clear_command_sequencer
  import dmacc_pkg::*;
#(
  parameter int unsigned SEED_BYTES      = 64,
  parameter int unsigned MAX_BLOCK_BYTES = 1048576
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [39:0] region_offset, [79:40] region_size, [80] dma_fault, [87:81] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [0] mode
  input  logic                 s_axis_tuser,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] control_word, [79:32] source_word, [127:80] dest_address,
  // [159:128] command_word
  output logic [OutDataW-1:0]  m_axis_tdata,
  // [0] cmd_valid, [1] status
  output logic [OutUserW-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned BlkW = $clog2(MAX_BLOCK_BYTES) + 1;
  localparam logic [BlkW-1:0]  SeedBlk  = BlkW'(SEED_BYTES);
  localparam logic [BlkW-1:0]  MaxBlk   = BlkW'(MAX_BLOCK_BYTES);
  localparam logic [AddrW-1:0] SeedAddr = AddrW'(SEED_BYTES);
  localparam logic [DoneW-1:0] SeedDone = DoneW'(SEED_BYTES);
  localparam logic [WordW-1:0] FillCmd  = CMD_FILL | (WordW'(SEED_BYTES) & FILL_COUNT_MASK);

  // configuration
  logic [FbLocW-1:0]   fb_location_q;
  logic [PatternW-1:0] fill_pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_location_q  <= '0;
      fill_pattern_q <= FILL_PATTERN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FB_LOCATION:  fb_location_q  <= cfg_wdata_i[FbLocW-1:0];
        CFG_FILL_PATTERN: fill_pattern_q <= cfg_wdata_i[PatternW-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic               in_mode;
  logic [OffsetW-1:0] in_offset;
  logic [SizeW-1:0]   in_size;
  logic               in_fault;

  assign in_mode   = s_axis_tuser;
  assign in_offset = s_axis_tdata[OffsetW-1:0];
  assign in_size   = s_axis_tdata[OffsetW+SizeW-1:OffsetW];
  assign in_fault  = s_axis_tdata[OffsetW+SizeW];

  // sequence state
  logic             active_q,      active_d;
  logic [AddrW-1:0] seed_addr_q,   seed_addr_d;
  logic [AddrW-1:0] next_dest_q,   next_dest_d;
  logic [DoneW-1:0] bytes_done_q,  bytes_done_d;
  logic [SizeW-1:0] total_q,       total_d;
  logic [BlkW-1:0]  block_q,       block_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t out_q,       out_d;

  logic s_fire, m_fire, produce;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_valid_q && m_axis_tready;
  assign produce       = (in_mode == MODE_START) || active_q;

  // copy step terms
  logic [DoneW:0]   sum_ext;
  logic [DoneW-1:0] remain;
  logic [BlkW-1:0]  blk_cur;
  logic [BlkW:0]    blk_dbl;
  logic [BlkW-1:0]  blk_grow;
  logic [DoneW-1:0] done_after;
  logic [AddrW-1:0] seed_new;

  always_comb begin
    sum_ext = {1'b0, bytes_done_q} + (DoneW+1)'(block_q);
    remain  = DoneW'(total_q) - bytes_done_q;
    // clamp the last block at the region end
    if (sum_ext > (DoneW+1)'(total_q)) begin
      blk_cur = remain[BlkW-1:0];
    end else begin
      blk_cur = block_q;
    end
    done_after = bytes_done_q + DoneW'(blk_cur);
    blk_dbl    = {blk_cur, 1'b0};
    if (blk_cur >= MaxBlk) begin
      blk_grow = blk_cur;
    end else if (blk_dbl > (BlkW+1)'(MaxBlk)) begin
      blk_grow = MaxBlk;
    end else begin
      blk_grow = blk_dbl[BlkW-1:0];
    end
    seed_new = AddrW'({fb_location_q, FbShift'(0)}) + AddrW'(in_offset);
  end

  always_comb begin
    active_d     = active_q;
    seed_addr_d  = seed_addr_q;
    next_dest_d  = next_dest_q;
    bytes_done_d = bytes_done_q;
    total_d      = total_q;
    block_d      = block_q;
    out_d        = out_q;

    if (in_fault) begin
      active_d           = 1'b0;
      out_d              = '0;
      out_d.last         = 1'b1;
      out_d.status       = 1'b1;
    end else if (in_mode == MODE_START) begin
      seed_addr_d        = seed_new;
      next_dest_d        = seed_new + SeedAddr;
      bytes_done_d       = SeedDone;
      total_d            = in_size;
      block_d            = SeedBlk;
      active_d           = SeedDone < DoneW'(in_size);
      out_d.cmd_valid    = 1'b1;
      out_d.control_word = CTRL_FILL;
      out_d.source_word  = AddrW'(fill_pattern_q);
      out_d.dest_address = seed_new;
      out_d.command_word = FillCmd;
      out_d.last         = SeedDone >= DoneW'(in_size);
      out_d.status       = 1'b0;
    end else begin
      next_dest_d        = next_dest_q + AddrW'(blk_cur);
      bytes_done_d       = done_after;
      block_d            = blk_grow;
      active_d           = done_after < DoneW'(total_q);
      out_d.cmd_valid    = 1'b1;
      out_d.control_word = CTRL_COPY;
      out_d.source_word  = seed_addr_q;
      out_d.dest_address = next_dest_q;
      out_d.command_word = CMD_COPY | WordW'(blk_cur);
      out_d.last         = done_after >= DoneW'(total_q);
      out_d.status       = 1'b0;
    end
  end

  always_comb begin
    if (s_fire && produce) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      // a next item while idle leaves the state alone
      if (s_fire && produce) begin
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && produce) begin
      seed_addr_q  <= seed_addr_d;
      next_dest_q  <= next_dest_d;
      bytes_done_q <= bytes_done_d;
      total_q      <= total_d;
      block_q      <= block_d;
      out_q        <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.command_word, out_q.dest_address,
                          out_q.source_word, out_q.control_word};
  assign m_axis_tuser  = {out_q.status, out_q.cmd_valid};
  assign m_axis_tlast  = out_q.last;

  // a fault result never carries a command and always ends the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status) |-> (!out_q.cmd_valid && out_q.last))
    else $error("fault result carries a command or is not last");

  // loading a final result leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && produce && out_d.last) |=> !active_q)
    else $error("sequencer still active after final result");

  // a running sequence has always bytes left to copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (bytes_done_q < DoneW'(total_q)))
    else $error("active sequence with no bytes left");

  // an empty result register never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule
